>>> rtl/tra_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and sequence helpers for the TCP reassembly table.
// Used by tra_cell, tra_ctrl and tcp_reassembly_table.

package tra_pkg;

    localparam int TABLE_DEPTH_DEF = 8;
    localparam int SEQ_W           = 32;
    localparam int LEN_W           = 16;
    localparam int CFG_ADDR_W      = 3;
    localparam int CFG_DATA_W      = 32;
    localparam int S_DATA_W        = 48;
    localparam int M_DATA_W        = 80;
    localparam int M_USER_W        = 3;

    // register index taken from paddr[2]
    localparam logic REG_START_SEQ = 1'b0;

    typedef struct packed {
        logic             valid;
        logic [SEQ_W-1:0] seq;
        logic [LEN_W-1:0] len;
    } t_entry;

    typedef struct packed {
        logic clear;
        logic ins;
        logic pop;
    } t_cell_cmd;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CMP,
        S_SEL,
        S_INS,
        S_STAT,
        S_DRAIN
    } t_state;

    typedef enum logic [1:0] {
        STAT_ACCEPT = 2'd0,
        STAT_DUP    = 2'd1,
        STAT_FULL   = 2'd2
    } t_status;

    // a lies before b in 32-bit wraparound order
    function automatic logic seq_before(input logic [SEQ_W-1:0] a, input logic [SEQ_W-1:0] b);
        logic [SEQ_W-1:0] d;
        d = a - b;
        return d[SEQ_W-1];
    endfunction

endpackage

>>> rtl/tra_cell.sv
`timescale 1ns / 1ps
// One slot of the reassembly chain: holds a pending descriptor and its compare flags.
// Depends on tra_pkg.

module tra_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  tra_pkg::t_cell_cmd i_cmd,
    input  tra_pkg::t_entry    i_new,
    input  tra_pkg::t_entry    i_lo,
    input  tra_pkg::t_entry    i_hi,
    input  logic               i_pos,
    input  logic               i_shift,
    output tra_pkg::t_entry    o_entry,
    output logic               o_mark,
    output logic               o_eq
);

    logic                      r_valid;
    logic                      n_valid;
    logic [tra_pkg::SEQ_W-1:0] r_seq;
    logic [tra_pkg::SEQ_W-1:0] n_seq;
    logic [tra_pkg::LEN_W-1:0] r_len;
    logic [tra_pkg::LEN_W-1:0] n_len;
    logic                      r_mark;
    logic                      n_mark;
    logic                      r_eq;
    logic                      n_eq;
    logic                      same;

    assign same   = (r_seq == i_new.seq);
    assign n_mark = !r_valid || same || tra_pkg::seq_before(i_new.seq, r_seq);
    assign n_eq   = r_valid && same;

    always_comb begin
        n_valid = r_valid;
        n_seq   = r_seq;
        n_len   = r_len;
        if (i_cmd.clear) begin
            n_valid = 1'b0;
        end else if (i_cmd.ins) begin
            if (i_pos) begin
                n_valid = 1'b1;
                n_seq   = i_new.seq;
                n_len   = i_new.len;
            end else if (i_shift) begin
                n_valid = i_lo.valid;
                n_seq   = i_lo.seq;
                n_len   = i_lo.len;
            end
        end else if (i_cmd.pop) begin
            n_valid = i_hi.valid;
            n_seq   = i_hi.seq;
            n_len   = i_hi.len;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_seq  <= n_seq;
        r_len  <= n_len;
        r_mark <= n_mark;
        r_eq   <= n_eq;
    end

    assign o_entry.valid = r_valid;
    assign o_entry.seq   = r_seq;
    assign o_entry.len   = r_len;
    assign o_mark        = r_mark;
    assign o_eq          = r_eq;

endmodule

>>> rtl/tra_ctrl.sv
`timescale 1ns / 1ps
// Sequencer for the reassembly chain: insertion select, in-order drain, result register.
// Depends on tra_pkg; drives the tra_cell row through a t_cell_cmd.

module tra_ctrl #(
    parameter int TABLE_DEPTH = tra_pkg::TABLE_DEPTH_DEF,
    localparam int NCELL      = TABLE_DEPTH + 1
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_wr,
    input  logic [tra_pkg::SEQ_W-1:0]      i_cfg_value,
    input  logic                           i_s_valid,
    output logic                           o_s_ready,
    input  logic [tra_pkg::SEQ_W-1:0]      i_seg_seq,
    input  logic [tra_pkg::LEN_W-1:0]      i_seg_len,
    input  logic [NCELL-1:0]               i_mark,
    input  logic [NCELL-1:0]               i_eq,
    input  logic                           i_full,
    input  tra_pkg::t_entry                i_head,
    output tra_pkg::t_cell_cmd             o_cmd,
    output tra_pkg::t_entry                o_new,
    output logic [NCELL-1:0]               o_pos,
    output logic [NCELL-1:0]               o_shift,
    output logic                           o_m_valid,
    input  logic                           i_m_ready,
    output logic                           o_m_delivered,
    output logic [tra_pkg::SEQ_W-1:0]      o_m_seq,
    output logic [tra_pkg::LEN_W-1:0]      o_m_len,
    output logic [tra_pkg::SEQ_W-1:0]      o_m_expected,
    output tra_pkg::t_status               o_m_status,
    output logic                           o_m_last
);

    localparam logic [NCELL-1:0] ONE = {{(NCELL-1){1'b0}}, 1'b1};

    tra_pkg::t_state           r_state;
    tra_pkg::t_state           n_state;
    logic [tra_pkg::SEQ_W-1:0] r_seq;
    logic [tra_pkg::SEQ_W-1:0] n_seq;
    logic [tra_pkg::LEN_W-1:0] r_len;
    logic [tra_pkg::LEN_W-1:0] n_len;
    logic [tra_pkg::SEQ_W-1:0] r_next;
    logic [tra_pkg::SEQ_W-1:0] n_next;
    logic [NCELL-1:0]          r_pos;
    logic [NCELL-1:0]          n_pos;
    logic [NCELL-1:0]          r_shift;
    logic [NCELL-1:0]          n_shift;
    tra_pkg::t_status          r_stat;
    tra_pkg::t_status          n_stat;
    logic                      r_held_valid;
    logic                      n_held_valid;
    logic [tra_pkg::SEQ_W-1:0] r_held_seq;
    logic [tra_pkg::SEQ_W-1:0] n_held_seq;
    logic [tra_pkg::LEN_W-1:0] r_held_len;
    logic [tra_pkg::LEN_W-1:0] n_held_len;
    logic [tra_pkg::SEQ_W-1:0] r_held_exp;
    logic [tra_pkg::SEQ_W-1:0] n_held_exp;
    logic                      r_out_valid;
    logic                      n_out_valid;
    logic                      r_out_dlv;
    logic                      n_out_dlv;
    logic [tra_pkg::SEQ_W-1:0] r_out_seq;
    logic [tra_pkg::SEQ_W-1:0] n_out_seq;
    logic [tra_pkg::LEN_W-1:0] r_out_len;
    logic [tra_pkg::LEN_W-1:0] n_out_len;
    logic [tra_pkg::SEQ_W-1:0] r_out_exp;
    logic [tra_pkg::SEQ_W-1:0] n_out_exp;
    tra_pkg::t_status          r_out_status;
    tra_pkg::t_status          n_out_status;
    logic                      r_out_last;
    logic                      n_out_last;

    logic                      out_free;
    logic [NCELL-1:0]          sel_pos;
    logic                      sel_dup;
    logic                      sel_full;
    logic                      hd_deliver;
    logic                      hd_stale;
    logic                      hd_stop;
    logic [tra_pkg::SEQ_W-1:0] next_adv;
    logic                      accept;

    assign out_free   = !r_out_valid || i_m_ready;
    assign accept     = i_s_valid && o_s_ready;
    assign sel_pos    = i_mark & (~i_mark + ONE);
    assign sel_dup    = |(sel_pos & i_eq);
    assign sel_full   = i_full && (r_seq != r_next);
    assign hd_deliver = i_head.valid && (i_head.seq == r_next);
    assign hd_stale   = i_head.valid && !hd_deliver
                        && !tra_pkg::seq_before(r_next, i_head.seq);
    assign hd_stop    = !hd_deliver && !hd_stale;
    assign next_adv   = r_next + {{(tra_pkg::SEQ_W-tra_pkg::LEN_W){1'b0}}, i_head.len};

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            tra_pkg::S_IDLE:  if (i_s_valid) n_state = tra_pkg::S_CMP;
            tra_pkg::S_CMP:   n_state = tra_pkg::S_SEL;
            tra_pkg::S_SEL: begin
                if (sel_dup || sel_full) begin
                    n_state = tra_pkg::S_STAT;
                end else begin
                    n_state = tra_pkg::S_INS;
                end
            end
            tra_pkg::S_INS:   n_state = tra_pkg::S_DRAIN;
            tra_pkg::S_STAT:  if (out_free) n_state = tra_pkg::S_IDLE;
            tra_pkg::S_DRAIN: if (out_free && hd_stop) n_state = tra_pkg::S_IDLE;
            default:          n_state = tra_pkg::S_IDLE;
        endcase
    end

    // outputs to the stream side and the cell row
    always_comb begin
        o_s_ready   = 1'b0;
        o_cmd.clear = i_cfg_wr;
        o_cmd.ins   = 1'b0;
        o_cmd.pop   = 1'b0;
        case (r_state)
            tra_pkg::S_IDLE:  o_s_ready = 1'b1;
            tra_pkg::S_INS:   o_cmd.ins = 1'b1;
            tra_pkg::S_DRAIN: o_cmd.pop = out_free && !hd_stop;
            default: begin
                o_s_ready = 1'b0;
            end
        endcase
    end

    // datapath
    always_comb begin
        n_seq        = r_seq;
        n_len        = r_len;
        n_next       = r_next;
        n_pos        = r_pos;
        n_shift      = r_shift;
        n_stat       = r_stat;
        n_held_valid = r_held_valid;
        n_held_seq   = r_held_seq;
        n_held_len   = r_held_len;
        n_held_exp   = r_held_exp;
        n_out_valid  = r_out_valid && !i_m_ready;
        n_out_dlv    = r_out_dlv;
        n_out_seq    = r_out_seq;
        n_out_len    = r_out_len;
        n_out_exp    = r_out_exp;
        n_out_status = r_out_status;
        n_out_last   = r_out_last;

        if (i_cfg_wr) begin
            n_next = i_cfg_value;
        end
        if (accept) begin
            n_seq = i_seg_seq;
            n_len = i_seg_len;
        end

        case (r_state)
            tra_pkg::S_SEL: begin
                n_pos   = sel_pos;
                n_shift = ~(sel_pos - ONE) & ~sel_pos;
                n_stat  = sel_dup ? tra_pkg::STAT_DUP : tra_pkg::STAT_FULL;
            end
            tra_pkg::S_STAT: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_dlv    = 1'b0;
                    n_out_seq    = '0;
                    n_out_len    = '0;
                    n_out_exp    = r_next;
                    n_out_status = r_stat;
                    n_out_last   = 1'b1;
                end
            end
            tra_pkg::S_DRAIN: begin
                if (out_free) begin
                    if (hd_deliver) begin
                        n_next = next_adv;
                        if (r_held_valid) begin
                            n_out_valid  = 1'b1;
                            n_out_dlv    = 1'b1;
                            n_out_seq    = r_held_seq;
                            n_out_len    = r_held_len;
                            n_out_exp    = r_held_exp;
                            n_out_status = tra_pkg::STAT_ACCEPT;
                            n_out_last   = 1'b0;
                        end
                        n_held_valid = 1'b1;
                        n_held_seq   = i_head.seq;
                        n_held_len   = i_head.len;
                        n_held_exp   = next_adv;
                    end else if (hd_stop) begin
                        n_out_valid  = 1'b1;
                        n_out_dlv    = r_held_valid;
                        n_out_seq    = r_held_valid ? r_held_seq : '0;
                        n_out_len    = r_held_valid ? r_held_len : '0;
                        n_out_exp    = r_held_valid ? r_held_exp : r_next;
                        n_out_status = tra_pkg::STAT_ACCEPT;
                        n_out_last   = 1'b1;
                        n_held_valid = 1'b0;
                    end
                end
            end
            default: begin
                n_pos = r_pos;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= tra_pkg::S_IDLE;
            r_next       <= '0;
            r_held_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_next       <= n_next;
            r_held_valid <= n_held_valid;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_seq        <= n_seq;
        r_len        <= n_len;
        r_pos        <= n_pos;
        r_shift      <= n_shift;
        r_stat       <= n_stat;
        r_held_seq   <= n_held_seq;
        r_held_len   <= n_held_len;
        r_held_exp   <= n_held_exp;
        r_out_dlv    <= n_out_dlv;
        r_out_seq    <= n_out_seq;
        r_out_len    <= n_out_len;
        r_out_exp    <= n_out_exp;
        r_out_status <= n_out_status;
        r_out_last   <= n_out_last;
    end

    assign o_new.valid   = 1'b1;
    assign o_new.seq     = r_seq;
    assign o_new.len     = r_len;
    assign o_pos         = r_pos;
    assign o_shift       = r_shift;
    assign o_m_valid     = r_out_valid;
    assign o_m_delivered = r_out_dlv;
    assign o_m_seq       = r_out_seq;
    assign o_m_len       = r_out_len;
    assign o_m_expected  = r_out_exp;
    assign o_m_status    = r_out_status;
    assign o_m_last      = r_out_last;

endmodule

>>> rtl/tcp_reassembly_table.sv
`timescale 1ns / 1ps
// Top level of the TCP reassembly table: stream ports, APB register, cell row.
// Depends on tra_pkg, tra_cell and tra_ctrl.

// Segment descriptors enter on the slave stream one at a time. Pending
// descriptors sit in a row of TABLE_DEPTH+1 cells kept in sequence order; all
// cells compare against the new descriptor at once, the row shifts open to
// insert it, and the head cell is then drained one entry per cycle while the
// result output is free. A duplicate or table-full segment goes through CMP,
// SEL and STAT before the next input is taken; an accepted one goes through
// CMP, SEL, INS and DRAIN, popping head entries (delivered or discarded as
// stale); tready low on the master side holds STAT and DRAIN. Each delivery
// is a separate result transfer and the final result of a segment carries
// tlast. Writing start_seq sets the expected sequence and clears the row.

module tcp_reassembly_table #(
    parameter int TABLE_DEPTH = tra_pkg::TABLE_DEPTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // APB register port
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [tra_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [tra_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic [tra_pkg::CFG_DATA_W-1:0]   prdata,
    output logic                             pready,
    // segment descriptors
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [tra_pkg::S_DATA_W-1:0]     s_axis_tdata,  // seg_seq[31:0], seg_len[47:32]
    // results
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [tra_pkg::M_DATA_W-1:0]     m_axis_tdata,  // out_seq[31:0], out_len[47:32],
                                                            // expected_seq[79:48]
    output logic [tra_pkg::M_USER_W-1:0]     m_axis_tuser,  // delivered[0], status[2:1]
    output logic                             m_axis_tlast
);

    localparam int NCELL = TABLE_DEPTH + 1;

    logic [tra_pkg::CFG_DATA_W-1:0] r_start_seq;
    logic [tra_pkg::CFG_DATA_W-1:0] n_start_seq;
    logic                           cfg_wr;
    tra_pkg::t_cell_cmd             cmd;
    tra_pkg::t_entry                new_entry;
    tra_pkg::t_entry                entry [NCELL];
    logic [NCELL-1:0]               mark;
    logic [NCELL-1:0]               eq;
    logic [NCELL-1:0]               pos;
    logic [NCELL-1:0]               shift;
    logic                           m_dlv;
    logic [tra_pkg::SEQ_W-1:0]      m_seq;
    logic [tra_pkg::LEN_W-1:0]      m_len;
    logic [tra_pkg::SEQ_W-1:0]      m_exp;
    tra_pkg::t_status               m_status;

    assign pready      = 1'b1;
    assign cfg_wr      = psel && penable && pwrite && pready
                         && (paddr[2] == tra_pkg::REG_START_SEQ);
    assign n_start_seq = cfg_wr ? pwdata : r_start_seq;
    assign prdata      = (paddr[2] == tra_pkg::REG_START_SEQ) ? r_start_seq : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_seq <= '0;
        end else begin
            r_start_seq <= n_start_seq;
        end
    end

    for (genvar g = 0; g < NCELL; g++) begin : g_cell
        tra_pkg::t_entry lo;
        tra_pkg::t_entry hi;
        if (g == 0) begin : g_first
            assign lo = '0;
        end else begin : g_mid
            assign lo = entry[g-1];
        end
        if (g == NCELL - 1) begin : g_last
            assign hi = '0;
        end else begin : g_body
            assign hi = entry[g+1];
        end
        tra_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cmd   (cmd),
            .i_new   (new_entry),
            .i_lo    (lo),
            .i_hi    (hi),
            .i_pos   (pos[g]),
            .i_shift (shift[g]),
            .o_entry (entry[g]),
            .o_mark  (mark[g]),
            .o_eq    (eq[g])
        );
    end

    tra_ctrl #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr      (cfg_wr),
        .i_cfg_value   (pwdata),
        .i_s_valid     (s_axis_tvalid),
        .o_s_ready     (s_axis_tready),
        .i_seg_seq     (s_axis_tdata[31:0]),
        .i_seg_len     (s_axis_tdata[47:32]),
        .i_mark        (mark),
        .i_eq          (eq),
        .i_full        (entry[TABLE_DEPTH-1].valid),
        .i_head        (entry[0]),
        .o_cmd         (cmd),
        .o_new         (new_entry),
        .o_pos         (pos),
        .o_shift       (shift),
        .o_m_valid     (m_axis_tvalid),
        .i_m_ready     (m_axis_tready),
        .o_m_delivered (m_dlv),
        .o_m_seq       (m_seq),
        .o_m_len       (m_len),
        .o_m_expected  (m_exp),
        .o_m_status    (m_status),
        .o_m_last      (m_axis_tlast)
    );

    assign m_axis_tdata = {m_exp, m_len, m_seq};
    assign m_axis_tuser = {m_status, m_dlv};

endmodule

>>> tb/tcp_reassembly_table_tb.sv
`timescale 1ns / 1ps
// Testbench for tcp_reassembly_table: directed and random segment streams, checked
// result by result against a scoreboard that predicts the reassembly table.
// Depends on tra_pkg and the tcp_reassembly_table RTL.

module tcp_reassembly_table_tb;

    localparam int TBL_DEPTH    = tra_pkg::TABLE_DEPTH_DEF;
    localparam int LIMIT_CYCLES = 400000;
    localparam int TAIL_CYCLES  = 40;
    localparam int LONG_HOLD    = 400;
    localparam int RANDOM_ITEMS = 100;
    localparam int MAX_REPORTS  = 10;

    localparam logic [tra_pkg::CFG_ADDR_W-1:0] ADDR_START_SEQ = 3'd0;
    localparam logic [tra_pkg::CFG_ADDR_W-1:0] ADDR_UNMAPPED  = 3'd4;

    typedef struct packed {
        logic                      delivered;
        logic [tra_pkg::SEQ_W-1:0] seq;
        logic [tra_pkg::LEN_W-1:0] len;
        logic [tra_pkg::SEQ_W-1:0] expected;
        tra_pkg::t_status          status;
        logic                      last;
    } t_seg_result;

    class reassembly_scoreboard;
        logic [tra_pkg::SEQ_W-1:0] next_seq_q;
        logic [tra_pkg::SEQ_W-1:0] tab_seq [TBL_DEPTH];
        logic [tra_pkg::LEN_W-1:0] tab_len [TBL_DEPTH];
        int                        held;
        t_seg_result               expected_q [$];
        int                        errors;

        function new();
            next_seq_q = '0;
            held       = 0;
            errors     = 0;
        endfunction

        function bit behind(logic [tra_pkg::SEQ_W-1:0] a, logic [tra_pkg::SEQ_W-1:0] b);
            logic [tra_pkg::SEQ_W-1:0] diff;
            diff = a - b;
            return diff[tra_pkg::SEQ_W-1];
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void write_reg(logic [tra_pkg::CFG_ADDR_W-1:0] addr,
                                logic [tra_pkg::CFG_DATA_W-1:0] data);
            if (addr[2] == tra_pkg::REG_START_SEQ) begin
                next_seq_q = data;
                held       = 0;
            end
        endfunction

        function void push_status(tra_pkg::t_status st);
            t_seg_result r;
            r.delivered = 1'b0;
            r.seq       = '0;
            r.len       = '0;
            r.expected  = next_seq_q;
            r.status    = st;
            r.last      = 1'b1;
            expected_q.push_back(r);
        endfunction

        function void note_segment(logic [tra_pkg::SEQ_W-1:0] sq,
                                   logic [tra_pkg::LEN_W-1:0] ln);
            logic [tra_pkg::SEQ_W-1:0] m_seq [TBL_DEPTH+1];
            logic [tra_pkg::LEN_W-1:0] m_len [TBL_DEPTH+1];
            t_seg_result               res   [TBL_DEPTH+1];
            int                        pos, n, k, kept, i;
            bit                        found, stopped;
            pos   = held;
            found = 1'b0;
            for (i = 0; i < held && !found; i++) begin
                if (tab_seq[i] == sq) begin
                    push_status(tra_pkg::STAT_DUP);
                    return;
                end
                if (behind(sq, tab_seq[i])) begin
                    pos   = i;
                    found = 1'b1;
                end
            end
            if (held >= TBL_DEPTH && sq != next_seq_q) begin
                push_status(tra_pkg::STAT_FULL);
                return;
            end
            n = 0;
            for (i = 0; i < held; i++) begin
                if (i == pos) begin
                    m_seq[n] = sq;
                    m_len[n] = ln;
                    n++;
                end
                m_seq[n] = tab_seq[i];
                m_len[n] = tab_len[i];
                n++;
            end
            if (pos == held) begin
                m_seq[n] = sq;
                m_len[n] = ln;
                n++;
            end
            k       = 0;
            kept    = 0;
            stopped = 1'b0;
            for (i = 0; i < n; i++) begin
                if (!stopped && m_seq[i] == next_seq_q) begin
                    next_seq_q         = next_seq_q + m_len[i];
                    res[k].delivered   = 1'b1;
                    res[k].seq         = m_seq[i];
                    res[k].len         = m_len[i];
                    res[k].expected    = next_seq_q;
                    res[k].status      = tra_pkg::STAT_ACCEPT;
                    res[k].last        = 1'b0;
                    k++;
                end else if (!stopped && !behind(next_seq_q, m_seq[i])) begin
                    // drop stale entry
                end else begin
                    stopped = 1'b1;
                    if (kept < TBL_DEPTH) begin
                        tab_seq[kept] = m_seq[i];
                        tab_len[kept] = m_len[i];
                        kept++;
                    end
                end
            end
            held = kept;
            if (k == 0) begin
                push_status(tra_pkg::STAT_ACCEPT);
            end else begin
                res[k-1].last = 1'b1;
                for (i = 0; i < k; i++) expected_q.push_back(res[i]);
            end
        endfunction

        function void check_result(t_seg_result got);
            t_seg_result want;
            if (expected_q.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display({"unexpected result: delivered %0d seq %h len %h",
                              " exp_seq %h status %0d last %0d"},
                             got.delivered, got.seq, got.len, got.expected,
                             got.status, got.last);
                return;
            end
            want = expected_q.pop_front();
            if (got.delivered !== want.delivered || got.seq !== want.seq ||
                got.len !== want.len || got.expected !== want.expected ||
                got.status !== want.status || got.last !== want.last) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display({"mismatch (exp/act): delivered %0d/%0d seq %h/%h len %h/%h",
                              " exp_seq %h/%h status %0d/%0d last %0d/%0d"},
                             want.delivered, got.delivered, want.seq, got.seq,
                             want.len, got.len, want.expected, got.expected,
                             want.status, got.status, want.last, got.last);
            end
        endfunction

        function void close_out();
            if (expected_q.size() != 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0d expected results never arrived", expected_q.size());
            end
        endfunction
    endclass

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           psel;
    logic                           penable;
    logic                           pwrite;
    logic [tra_pkg::CFG_ADDR_W-1:0] paddr;
    logic [tra_pkg::CFG_DATA_W-1:0] pwdata;
    logic [tra_pkg::CFG_DATA_W-1:0] prdata;
    logic                           pready;
    logic                           s_axis_tvalid;
    logic                           s_axis_tready;
    logic [tra_pkg::S_DATA_W-1:0]   s_axis_tdata;   // seg_seq[31:0], seg_len[47:32]
    logic                           m_axis_tvalid;
    logic                           m_axis_tready;
    logic [tra_pkg::M_DATA_W-1:0]   m_axis_tdata;   // out_seq[31:0], out_len[47:32],
                                                    // expected_seq[79:48]
    logic [tra_pkg::M_USER_W-1:0]   m_axis_tuser;   // delivered[0], status[2:1]
    logic                           m_axis_tlast;

    reassembly_scoreboard sb;
    t_seg_result          observed;
    int                   cycle_count;
    int                   sent_items;
    int                   hold_request;
    int                   rx_hold;
    int                   rx_busy;
    int                   rx_run;
    bit                   fast_phase;

    tcp_reassembly_table #(
        .TABLE_DEPTH(TBL_DEPTH)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            observed.delivered = m_axis_tuser[0];
            observed.seq       = m_axis_tdata[31:0];
            observed.len       = m_axis_tdata[47:32];
            observed.expected  = m_axis_tdata[79:48];
            observed.status    = tra_pkg::t_status'(m_axis_tuser[2:1]);
            observed.last      = m_axis_tlast;
            sb.check_result(observed);
        end
    end

    // receiver: random ready pattern, plus a long hold on request
    always @(posedge i_clk) begin
        if (hold_request > 0) begin
            rx_hold      = hold_request;
            hold_request = 0;
        end
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (rx_hold > 0) begin
            rx_hold--;
            m_axis_tready <= 1'b0;
        end else if (rx_busy > 0) begin
            rx_busy--;
            m_axis_tready <= 1'b0;
        end else if (rx_run > 0) begin
            rx_run--;
            m_axis_tready <= 1'b1;
        end else begin
            rx_run  = $urandom_range(1, 30);
            rx_busy = gap_len();
            m_axis_tready <= 1'b1;
        end
    end

    task automatic send_segment(input logic [tra_pkg::SEQ_W-1:0] sq,
                                input logic [tra_pkg::LEN_W-1:0] ln);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {ln, sq};
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_segment(sq, ln);
        sent_items++;
    endtask

    task automatic idle_input(input int cycles);
        if (cycles > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (cycles) @(posedge i_clk);
        end
    endtask

    task automatic send_paced(input logic [tra_pkg::SEQ_W-1:0] sq,
                              input logic [tra_pkg::LEN_W-1:0] ln);
        send_segment(sq, ln);
        idle_input(fast_phase ? 0 : gap_len());
    endtask

    task automatic wait_results();
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    task automatic apb_write(input logic [tra_pkg::CFG_ADDR_W-1:0] addr,
                             input logic [tra_pkg::CFG_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.write_reg(addr, data);
    endtask

    initial begin
        logic [tra_pkg::SEQ_W-1:0] base, cursor, tmp_seq;
        logic [tra_pkg::LEN_W-1:0] ln, tmp_len;
        logic [tra_pkg::SEQ_W-1:0] run_seq [$];
        logic [tra_pkg::LEN_W-1:0] run_len [$];
        int                        phase, nseg, i, j, r;
        bit                        full_mix;

        i_rst_n       = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        cycle_count   = 0;
        sent_items    = 0;
        hold_request  = 0;
        rx_hold       = 0;
        rx_busy       = 0;
        rx_run        = 0;
        fast_phase    = 1'b0;
        sb            = new();

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset state: zero length, max length, stale entry
        send_paced(32'h0000_0000, 16'h0000);
        send_paced(32'h0000_0000, 16'hFFFF);
        send_paced(32'hFFFF_FFFF, 16'h0005);
        wait_results();

        // out of order across the wrap, duplicate, multi-delivery
        base = 32'hFFFF_FFF0;
        apb_write(ADDR_START_SEQ, base);
        send_paced(base + 32'd16, 16'd8);
        send_paced(base + 32'd32, 16'd4);
        send_paced(base + 32'd16, 16'd8);
        send_paced(base + 32'd8, 16'd8);
        send_paced(base, 16'd8);
        send_paced(32'h0000_0008, 16'd8);

        // fill the table, then full drop, duplicate while full, full but deliverable
        for (i = TBL_DEPTH - 1; i >= 0; i--)
            send_paced(32'h0000_0100 + 32'd16 * i, 16'd16);
        send_paced(32'h0000_0050, 16'd4);
        send_paced(32'h0000_0100, 16'd4);
        send_paced(32'h0000_0014, 16'h00EC);
        wait_results();

        // write to an unmapped register must leave the state alone
        apb_write(ADDR_UNMAPPED, 32'h1234_5678);
        send_paced(32'h0000_0180, 16'd3);

        phase = 0;
        while (sent_items < RANDOM_ITEMS) begin
            wait_results();
            case (phase % 6)
                0:       base = 32'hFFFF_FFFF;
                1:       base = 32'h7FFF_FFF0;
                2:       base = 32'h0000_0000;
                3:       base = 32'h8000_0000 - $urandom_range(0, 64);
                default: base = $urandom();
            endcase
            apb_write(ADDR_START_SEQ, base);
            fast_phase = ($urandom_range(0, 3) == 0);
            nseg       = $urandom_range(2, 12);
            if (phase == 1) begin
                nseg         = 12;
                hold_request = LONG_HOLD;
            end
            run_seq.delete();
            run_len.delete();
            cursor = base;
            for (i = 0; i < nseg; i++) begin
                r = $urandom_range(0, 9);
                if (r == 0) ln = '0;
                else if (r == 1) ln = tra_pkg::LEN_W'($urandom());
                else ln = tra_pkg::LEN_W'($urandom_range(1, 64));
                run_seq.push_back(cursor);
                run_len.push_back(ln);
                cursor = cursor + ln;
            end
            full_mix = $urandom_range(0, 1);
            for (i = nseg - 1; i > 0; i--) begin
                if (full_mix) j = $urandom_range(0, i);
                else j = ($urandom_range(0, 2) == 0) ? i - 1 : i;
                tmp_seq    = run_seq[i];
                tmp_len    = run_len[i];
                run_seq[i] = run_seq[j];
                run_len[i] = run_len[j];
                run_seq[j] = tmp_seq;
                run_len[j] = tmp_len;
            end
            for (i = 0; i < nseg; i++) begin
                send_paced(run_seq[i], run_len[i]);
                r = $urandom_range(0, 9);
                if (r == 0) begin
                    j = $urandom_range(0, i);
                    send_paced(run_seq[j], run_len[j]);
                end else if (r == 1) begin
                    send_paced($urandom(), tra_pkg::LEN_W'($urandom()));
                end
            end
            phase++;
        end

        wait_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        sb.close_out();
        if (sb.errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

>>> tcp_reassembly_table.f
rtl/tra_pkg.sv
rtl/tra_cell.sv
rtl/tra_ctrl.sv
rtl/tcp_reassembly_table.sv
tb/tcp_reassembly_table_tb.sv
